// File: hw/rtl/frq_pkg.sv
// Shared types and constants for the run queue scheduler.
package frq_pkg;

  localparam int ID_W            = 16;
  localparam int OCC_W           = 5;
  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    KIND_ENQ   = 2'd0,
    KIND_DEQ   = 2'd1,
    KIND_YIELD = 2'd2,
    KIND_PICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  // Per-slot control from the sequencer to one cell.
  typedef struct packed {
    logic cmp;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: hw/rtl/fifo_run_queue_scheduler_core.sv
// Run queue scheduler: sequencer plus a chain of slot cells.
// The result strobe follows the start transfer through ST_CMP and ST_APPLY,
//   the per-slot compare register and the shift/load apply step. A new
//   start is taken only while busy is low, which includes the cycle that
//   the previous result is on out_*.
// Reset (rst_n low, synchronous): queue empty, sequencer idle, no strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fifo_run_queue_scheduler_core
  import frq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [ID_W-1:0]  in_task_id,
  output logic             out_valid,
  output logic [ID_W-1:0]  out_picked_id,
  output logic [1:0]       out_status,
  output logic [OCC_W-1:0] out_occupancy
);

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int LVLS = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  kind_t           kind_r;
  logic [ID_W-1:0] id_r;
  logic [CW-1:0]   count_r, count_nxt;

  logic             out_valid_r;
  logic [ID_W-1:0]  out_picked_id_r, picked_nxt;
  status_t          out_status_r, status_nxt;
  logic [OCC_W-1:0] out_occupancy_r;

  logic [ID_W-1:0]        cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match_vec;
  logic [QUEUE_DEPTH-1:0] found_incl;
  cell_ctl_t              cell_ctl [QUEUE_DEPTH];

  logic          accept;
  logic          apply;
  logic          full;
  logic          any_found;
  logic          do_shift;
  logic          do_load;
  logic [CW-1:0] tail_idx;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign apply  = (state_r == ST_APPLY);

  // Sequencer: latch the command, compare in all slots, then apply.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CMP;
      end
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      id_r   <= in_task_id;
    end
  end

  // Inclusive prefix OR of slot matches: every slot at or above the first
  // match takes its upper neighbor, which closes the gap.
  always_comb begin
    logic [QUEUE_DEPTH-1:0] lvl;
    logic [QUEUE_DEPTH-1:0] tmp;
    lvl = match_vec;
    for (int l = 0; l < LVLS; l++) begin
      tmp = lvl;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i >= (1 << l)) tmp[i] = lvl[i] | lvl[i - (1 << l)];
      end
      lvl = tmp;
    end
    found_incl = lvl;
  end

  assign any_found = found_incl[QUEUE_DEPTH-1];
  assign full      = (count_r == CW'(QUEUE_DEPTH));

  // Decide the outcome of the latched command.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    picked_nxt = '0;
    do_shift   = 1'b0;
    do_load    = 1'b0;
    tail_idx   = count_r;
    unique case (kind_r)
      KIND_ENQ: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          do_load   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_DEQ: begin
        if (!any_found) begin
          status_nxt = STAT_ABSENT;
        end else begin
          do_shift  = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      KIND_YIELD: begin
        tail_idx = count_r - CW'(1);
        if (!any_found) begin
          status_nxt = STAT_ABSENT;
        end else begin
          do_shift = 1'b1;
          do_load  = 1'b1;
        end
      end
      KIND_PICK: begin
        if (count_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          picked_nxt = cell_data[0];
        end
      end
      default: status_nxt = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= apply;
      if (apply) count_r <= count_nxt;
    end
  end

  // Hold the result fields for the strobe cycle.
  always_ff @(posedge clk) begin
    if (apply) begin
      out_picked_id_r <= picked_nxt;
      out_status_r    <= status_nxt;
      out_occupancy_r <= OCC_W'(count_nxt);
    end
  end

  // Chain of slot cells; slot 0 is the head.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_W-1:0] upper;

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_data[g+1];
    end

    assign cell_ctl[g].cmp   = (state_r == ST_CMP);
    assign cell_ctl[g].shift = apply && do_shift && found_incl[g];
    assign cell_ctl[g].load  = apply && do_load && (tail_idx == CW'(g));

    frq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .count     (count_r),
      .id        (id_r),
      .next_data (upper),
      .data_o    (cell_data[g]),
      .match_o   (match_vec[g])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_picked_id = out_picked_id_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

endmodule

// File: hw/rtl/frq_cell.sv
// One queue slot: holds a task id, compares it, shifts from its upper neighbor.
module frq_cell
  import frq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [CW-1:0]   count,
  input  logic [ID_W-1:0] id,
  input  logic [ID_W-1:0] next_data,
  output logic [ID_W-1:0] data_o,
  output logic            match_o
);

  logic [ID_W-1:0] data_r;
  logic            match_r;
  logic            occupied;

  assign occupied = (count > CW'(IDX));

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match_r <= occupied && (data_r == id);
    end
    // Load wins: the tail slot of a yield takes the id, not its neighbor.
    if (ctl.load) begin
      data_r <= id;
    end else if (ctl.shift) begin
      data_r <= next_data;
    end
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule
